// ===== design/srrw_pkg.sv =====
// shared types and constants of the selective repeat receive window
// no dependencies
package srrw_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int WSZ_W      = 6;

    localparam logic [CFG_IDX_W-1:0] REG_SEQ_MODULUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] SEQ_MODULUS_RST = 16'd8;
    localparam logic [WSZ_W-1:0]      WINDOW_SIZE_RST = 6'd4;

    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_REL  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_REL,
        ST_SLIDE,
        ST_NORM
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic rel;
        logic slide;
        logic norm_load;
        logic norm_step;
        logic norm_commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic mod_wr;
        logic go_rel;
        logic rel_more;
        logic norm_done;
    } t_dp_status;

endpackage

// ===== design/srrw_rem.sv =====
// bit serial remainder unit, one quotient bit per step
// depends on nothing; loaded and stepped by the datapath
module srrw_rem #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic         i_step,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic [W-1:0] o_rem
);

    logic [W-1:0] r_x;
    logic [W:0]   r_rem;
    logic [W:0]   trial;

    assign trial = {r_rem[W-1:0], r_x[W-1]};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x   <= i_dividend;
            r_rem <= '0;
        end else if (i_step) begin
            r_x <= {r_x[W-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                r_rem <= trial - {1'b0, i_divisor};
            end else begin
                r_rem <= trial;
            end
        end
    end

    assign o_rem = r_rem[W-1:0];

endmodule

// ===== design/srrw_ctrl.sv =====
// controller state machine of the receive window
// depends on srrw_pkg; drives srrw_datapath through command and status structs
module srrw_ctrl
    import srrw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       busy
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = (r_state == ST_IDLE) && start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = i_status.go_rel ? ST_REL : ST_IDLE;
            end
            ST_REL: begin
                n_state = i_status.rel_more ? ST_REL : ST_SLIDE;
            end
            ST_SLIDE: begin
                n_state = ST_IDLE;
            end
            ST_NORM: begin
                if (i_status.norm_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_status.mod_wr && !accept) begin
            n_state = ST_NORM;
        end
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.capture     = accept;
        o_cmd.norm_load   = i_status.mod_wr && !accept;
        case (r_state)
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            ST_REL: begin
                o_cmd.rel = 1'b1;
            end
            ST_SLIDE: begin
                o_cmd.slide = 1'b1;
            end
            ST_NORM: begin
                o_cmd.norm_step   = !i_status.norm_done && !i_status.mod_wr;
                o_cmd.norm_commit = i_status.norm_done && !i_status.mod_wr;
            end
            default: begin
                o_cmd.eval = 1'b0;
            end
        endcase
        busy = (r_state != ST_IDLE);
    end

endmodule

// ===== design/srrw_datapath.sv =====
// datapath: config registers, window slots, sequence arithmetic, result register
// depends on srrw_pkg and srrw_rem; sequenced by srrw_ctrl
module srrw_datapath
    import srrw_pkg::*;
#(
    parameter int MAX_WINDOW = 32,
    parameter int SEQ_BITS   = 16,
    parameter int TAG_BITS   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_action,
    input  logic [SEQ_BITS-1:0]   i_seq,
    input  logic                  i_crc_ok,
    input  logic [TAG_BITS-1:0]   i_buffer_tag,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    output logic                  o_valid,
    output logic [1:0]            o_kind,
    output logic [SEQ_BITS-1:0]   o_ack_seq,
    output logic [TAG_BITS-1:0]   o_release_tag,
    output logic                  o_last
);

    localparam int WCNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W  = (SEQ_BITS > WCNT_W) ? SEQ_BITS : WCNT_W;
    localparam int NCNT_W = $clog2(SEQ_BITS + 1);

    // configuration
    logic [CFG_DATA_W-1:0]          r_mod;
    logic [WSZ_W-1:0]               r_wsz;
    logic [SEQ_BITS+CFG_DATA_W-1:0] mod_x;
    logic [SEQ_BITS-1:0]            mod_s;
    logic [SEQ_BITS-1:0]            m_eff;
    logic [WCNT_W-1:0]              w_eff;

    // captured transaction
    logic                r_action;
    logic [SEQ_BITS-1:0] r_seq;
    logic                r_crc;
    logic [TAG_BITS-1:0] r_tag;

    // window state
    logic [SEQ_BITS-1:0] r_base_raw;
    logic [SEQ_BITS-1:0] r_behind_raw;
    logic [SEQ_BITS-1:0] r_base;
    logic [SEQ_BITS-1:0] r_behind;
    logic [SEQ_BITS-1:0] n_base;
    logic [SEQ_BITS-1:0] n_behind;
    logic                r_acked [MAX_WINDOW];
    logic                n_acked [MAX_WINDOW];
    logic [TAG_BITS-1:0] r_tags  [MAX_WINDOW];
    logic [TAG_BITS-1:0] n_tags  [MAX_WINDOW];
    logic [WCNT_W-1:0]   r_run;

    // normalization
    logic [NCNT_W-1:0]   r_ncnt;
    logic [SEQ_BITS-1:0] rem_base;
    logic [SEQ_BITS-1:0] rem_behind;

    // evaluation
    logic [SEQ_BITS-1:0] off;
    logic [SEQ_BITS-1:0] d_seq;
    logic [SEQ_BITS-1:0] d_base;
    logic [CMP_W-1:0]    off_x;
    logic [CMP_W-1:0]    w_x;
    logic [SLOT_W-1:0]   slot;
    logic                is_end;
    logic                seq_in;
    logic                in_win;
    logic                store;
    logic                go_rel;
    logic                behind_hit;
    logic                acked_1;
    logic                rel_more;
    logic [SEQ_BITS:0]   m_inc;
    logic [SEQ_BITS-1:0] half;
    logic [SEQ_BITS-1:0] base_inc;

    // result register
    logic                r_valid;
    logic [1:0]          r_kind;
    logic [SEQ_BITS-1:0] r_ack_seq;
    logic [TAG_BITS-1:0] r_rel_tag;
    logic                r_last;
    logic                n_valid;
    logic [1:0]          n_kind;
    logic [SEQ_BITS-1:0] n_ack_seq;
    logic [TAG_BITS-1:0] n_rel_tag;
    logic                n_last;

    assign mod_x = {{SEQ_BITS{1'b0}}, r_mod};
    assign mod_s = mod_x[SEQ_BITS-1:0];
    assign m_eff = (mod_s < SEQ_BITS'(2)) ? SEQ_BITS'(2) : mod_s;

    always_comb begin
        if (r_wsz == '0) begin
            w_eff = WCNT_W'(1);
        end else if (r_wsz > WSZ_W'(MAX_WINDOW)) begin
            w_eff = WCNT_W'(MAX_WINDOW);
        end else begin
            w_eff = WCNT_W'(r_wsz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= SEQ_MODULUS_RST;
            r_wsz <= WINDOW_SIZE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_SEQ_MODULUS) begin
                r_mod <= i_cfg_data;
            end
            if (i_cfg_index == REG_WINDOW_SIZE) begin
                r_wsz <= i_cfg_data[WSZ_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_seq    <= i_seq;
            r_crc    <= i_crc_ok;
            r_tag    <= i_buffer_tag;
        end
    end

    // circular differences
    assign off    = r_seq - r_base + ((r_seq < r_base) ? m_eff : '0);
    assign d_seq  = r_seq - r_behind + ((r_seq < r_behind) ? m_eff : '0);
    assign d_base = r_base - r_behind + ((r_base < r_behind) ? m_eff : '0);
    assign off_x  = CMP_W'(off);
    assign w_x    = CMP_W'(w_eff);
    assign slot   = off_x[SLOT_W-1:0];

    assign is_end     = (r_action == ACT_END);
    assign seq_in     = (r_seq < m_eff);
    assign in_win     = (off_x < w_x);
    assign store      = !is_end && seq_in && in_win && r_crc;
    assign go_rel     = store && (off == '0);
    assign behind_hit = !is_end && seq_in && !in_win && (d_seq < d_base);

    generate
        if (MAX_WINDOW > 1) begin : g_ack1
            assign acked_1 = r_acked[1];
        end else begin : g_ack1_none
            assign acked_1 = 1'b0;
        end
    endgenerate

    assign rel_more = (({1'b0, r_run} + 1'b1) < {1'b0, w_eff}) && acked_1;

    assign base_inc = r_base + 1'b1;
    assign m_inc    = {1'b0, m_eff} + 1'b1;
    assign half     = SEQ_BITS'(m_inc >> 1) - 1'b1;

    always_comb begin
        n_base   = r_base;
        n_behind = r_behind;
        if (i_cmd.rel) begin
            n_base = (base_inc == m_eff) ? '0 : base_inc;
        end
        if (i_cmd.slide) begin
            n_behind = r_base - half + ((r_base < half) ? m_eff : '0);
        end
        if (i_cmd.norm_commit) begin
            n_base   = rem_base;
            n_behind = rem_behind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_raw   <= '0;
            r_behind_raw <= '0;
            r_base       <= '0;
            r_behind     <= '0;
            r_run        <= '0;
            r_ncnt       <= '0;
        end else begin
            r_base   <= n_base;
            r_behind <= n_behind;
            if (i_cmd.slide) begin
                r_base_raw   <= r_base;
                r_behind_raw <= n_behind;
            end
            if (i_cmd.rel) begin
                r_run <= r_run + 1'b1;
            end else if (i_cmd.slide) begin
                r_run <= '0;
            end
            if (i_cmd.norm_load) begin
                r_ncnt <= '0;
            end else if (i_cmd.norm_step) begin
                r_ncnt <= r_ncnt + 1'b1;
            end
        end
    end

    srrw_rem #(
        .W (SEQ_BITS)
    ) u_rem_base (
        .i_clk      (i_clk),
        .i_load     (i_cmd.norm_load),
        .i_step     (i_cmd.norm_step),
        .i_dividend (r_base_raw),
        .i_divisor  (m_eff),
        .o_rem      (rem_base)
    );

    srrw_rem #(
        .W (SEQ_BITS)
    ) u_rem_behind (
        .i_clk      (i_clk),
        .i_load     (i_cmd.norm_load),
        .i_step     (i_cmd.norm_step),
        .i_dividend (r_behind_raw),
        .i_divisor  (m_eff),
        .o_rem      (rem_behind)
    );

    // slot store, write at the frame offset or shift down by one on release
    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_slot
            if (gi < MAX_WINDOW - 1) begin : g_mid
                always_comb begin
                    n_acked[gi] = r_acked[gi];
                    n_tags[gi]  = r_tags[gi];
                    if (i_cmd.eval && store && (slot == SLOT_W'(gi))) begin
                        n_acked[gi] = 1'b1;
                        n_tags[gi]  = r_tag;
                    end else if (i_cmd.rel) begin
                        if ({1'b0, w_eff} > (WCNT_W+1)'(gi + 1)) begin
                            n_acked[gi] = r_acked[gi+1];
                            n_tags[gi]  = r_tags[gi+1];
                        end else if ({1'b0, w_eff} == (WCNT_W+1)'(gi + 1)) begin
                            n_acked[gi] = 1'b0;
                        end
                    end
                end
            end else begin : g_end
                always_comb begin
                    n_acked[gi] = r_acked[gi];
                    n_tags[gi]  = r_tags[gi];
                    if (i_cmd.eval && store && (slot == SLOT_W'(gi))) begin
                        n_acked[gi] = 1'b1;
                        n_tags[gi]  = r_tag;
                    end else if (i_cmd.rel) begin
                        if ({1'b0, w_eff} == (WCNT_W+1)'(gi + 1)) begin
                            n_acked[gi] = 1'b0;
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_acked[i] <= 1'b0;
            end
        end else begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_acked[i] <= n_acked[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            r_tags[i] <= n_tags[i];
        end
    end

    always_comb begin
        n_valid   = 1'b0;
        n_kind    = KIND_ACK;
        n_ack_seq = '0;
        n_rel_tag = '0;
        n_last    = 1'b0;
        if (i_cmd.eval) begin
            if (is_end) begin
                n_valid = 1'b1;
                n_kind  = KIND_DONE;
                n_last  = 1'b1;
            end else if (store) begin
                n_valid   = 1'b1;
                n_ack_seq = r_seq;
                n_last    = !go_rel;
            end else if (behind_hit) begin
                n_valid   = 1'b1;
                n_ack_seq = r_seq;
                n_last    = 1'b1;
            end
        end
        if (i_cmd.rel) begin
            n_valid   = 1'b1;
            n_kind    = KIND_REL;
            n_rel_tag = r_tags[0];
            n_last    = !rel_more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_ack_seq <= n_ack_seq;
        r_rel_tag <= n_rel_tag;
        r_last    <= n_last;
    end

    assign o_status.mod_wr    = i_cfg_we && (i_cfg_index == REG_SEQ_MODULUS);
    assign o_status.go_rel    = go_rel;
    assign o_status.rel_more  = rel_more;
    assign o_status.norm_done = (r_ncnt == NCNT_W'(SEQ_BITS));

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_ack_seq     = r_ack_seq;
    assign o_release_tag = r_rel_tag;
    assign o_last        = r_last;

endmodule

// ===== design/selective_repeat_receive_window.sv =====
// top level of the selective repeat receive window
// depends on srrw_pkg, srrw_ctrl, srrw_datapath and srrw_rem
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------------
//  frame in  | start, busy            | i_action, i_seq, i_crc_ok, i_buffer_tag
//  result    | o_valid (one cycle)    | o_kind, o_ack_seq, o_release_tag, o_last
//  config    | i_cfg_we               | i_cfg_index, i_cfg_data
//
// a frame or end transaction is captured in idle and checked in the eval state; a frame
// that fills the window base then goes through the release state, one in-order release
// per cycle, and then the slide state; a write of seq_modulus re-reduces base and behind
// limit with two bit serial remainder units, and busy stays high until they are done
// reset is synchronous, active low, and clears the acked flags and window state
// results leave as one-cycle strobes; the receiver cannot stall them
module selective_repeat_receive_window
    import srrw_pkg::*;
#(
    parameter int MAX_WINDOW = 32,
    parameter int SEQ_BITS   = 16,
    parameter int TAG_BITS   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_action,
    input  logic [SEQ_BITS-1:0]   i_seq,
    input  logic                  i_crc_ok,
    input  logic [TAG_BITS-1:0]   i_buffer_tag,
    output logic                  o_valid,
    output logic [1:0]            o_kind,
    output logic [SEQ_BITS-1:0]   o_ack_seq,
    output logic [TAG_BITS-1:0]   o_release_tag,
    output logic                  o_last
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    srrw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    srrw_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .SEQ_BITS   (SEQ_BITS),
        .TAG_BITS   (TAG_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_seq         (i_seq),
        .i_crc_ok      (i_crc_ok),
        .i_buffer_tag  (i_buffer_tag),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_ack_seq     (o_ack_seq),
        .o_release_tag (o_release_tag),
        .o_last        (o_last)
    );

endmodule
